FILE: rtl/core/sdtc_pkg.sv
// sdtc_pkg: control word, microcode program and shared helpers for the
// shake-driven tilt color block. Depends on nothing; used by every design module.
package sdtc_pkg;

	localparam int STEP_W = 4;

	localparam logic [STEP_W-1:0] STEP_BLACK = 4'd8;

	typedef enum logic [1:0] {
		MUL_SQ,
		MUL_Y,
		MUL_T
	} mul_sel_t;

	typedef struct packed {
		logic [STEP_W-1:0] jump;
		logic              br_fail;
		mul_sel_t          mul_sel;
		logic              ld_shake;
		logic              ld_prod;
		logic              ld_level;
		logic              ld_base;
		logic              ld_phase;
		logic              emit;
		logic              black;
		logic              last;
	} ctrl_t;

	function automatic ctrl_t rom_word(input logic [STEP_W-1:0] pc);
		ctrl_t w;
		w = '0;
		unique case (pc)
			4'd0: begin
				w.ld_shake = 1'b1;
				w.br_fail  = 1'b1;
				w.jump     = STEP_BLACK;
			end
			4'd1: begin
				w.mul_sel = MUL_SQ;
				w.ld_prod = 1'b1;
			end
			4'd2: w.ld_level = 1'b1;
			4'd3: begin
				w.mul_sel = MUL_Y;
				w.ld_prod = 1'b1;
			end
			4'd4: w.ld_base = 1'b1;
			4'd5: w.ld_phase = 1'b1;
			4'd6: begin
				w.mul_sel = MUL_T;
				w.ld_prod = 1'b1;
			end
			4'd7: begin
				w.emit = 1'b1;
				w.last = 1'b1;
			end
			STEP_BLACK: begin
				w.emit  = 1'b1;
				w.black = 1'b1;
				w.last  = 1'b1;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] bitrev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
		logic [7:0] r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > 12'sd255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/sdtc_seq.sv
// sdtc_seq: step counter and microcode fetch for the tilt color block.
// Depends on sdtc_pkg (ctrl_t, rom_word, STEP_W).
module sdtc_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    fail,
	input  logic                    out_free,
	output logic                    busy,
	output sdtc_pkg::ctrl_t         ctrl
);

	logic                         busy_q;
	logic [sdtc_pkg::STEP_W-1:0]  pc_q;
	sdtc_pkg::ctrl_t              word;

	assign word = sdtc_pkg::rom_word(pc_q);
	assign ctrl = busy_q ? word : '0;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end
		end else if (word.emit && !out_free) begin
			// hold until the output word is free
			pc_q <= pc_q;
		end else if (word.last) begin
			busy_q <= 1'b0;
		end else if (word.br_fail && fail) begin
			pc_q <= word.jump;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

FILE: rtl/core/sdtc_dp.sv
// sdtc_dp: datapath of the tilt color block: sample, state, shared multiplier
// and output word. Depends on sdtc_pkg (ctrl_t, mul_sel_t, helpers).
module sdtc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [7:0]  accel_x,
	input  logic signed [7:0]  accel_y,
	input  logic signed [7:0]  accel_z,
	input  logic               flicker,
	input  logic               read_failed,
	input  sdtc_pkg::ctrl_t    ctrl,
	input  logic               out_stall,
	output logic               fail,
	output logic               out_free,
	output logic               out_valid,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	logic signed [7:0]  x_q, y_q, z_q;
	logic               flick_q, fail_q;
	logic signed [7:0]  px_q, py_q, pz_q;
	logic [12:0]        level_q;
	logic [15:0]        phase_q;
	logic [6:0]         shake_q;
	logic signed [17:0] prod_q;
	logic signed [10:0] r_q, g_q, b_q;
	logic               out_valid_q;
	logic [7:0]         red_q, green_q, blue_q;

	logic signed [8:0]  dx, dy, dz;
	logic [7:0]         ax, ay, az;
	logic [8:0]         ssum;
	logic [6:0]         shake_n;
	logic signed [16:0] lvl_sum;
	logic [12:0]        level_n;
	logic signed [17:0] z128, g_pre, b_pre;
	logic signed [10:0] x2, z2;
	logic [15:0]        ph_inc;
	logic signed [9:0]  t0, t1;
	logic signed [8:0]  mul_a, mul_b;
	logic signed [8:0]  offs;
	logic               apply;
	logic signed [11:0] offs_add, sum_r, sum_g, sum_b;

	always_comb begin
		dx = {px_q[7], px_q} - {x_q[7], x_q};
		dy = {py_q[7], py_q} - {y_q[7], y_q};
		dz = {pz_q[7], pz_q} - {z_q[7], z_q};
		ax = dx[8] ? 8'(-dx) : dx[7:0];
		ay = dy[8] ? 8'(-dy) : dy[7:0];
		az = dz[8] ? 8'(-dz) : dz[7:0];
		ssum = {2'b0, ax[7:1]} + {2'b0, ay[7:1]} + {2'b0, az[7:1]};
		shake_n = (ssum > 9'd127) ? 7'd127 : ssum[6:0];
	end

	always_comb begin
		lvl_sum = $signed({4'b0, level_q}) + $signed({3'b0, prod_q[13:0]}) - 17'sd5;
		if (lvl_sum < 0) begin
			level_n = 13'd0;
		end else if (lvl_sum > 17'sd8191) begin
			level_n = 13'd8191;
		end else begin
			level_n = lvl_sum[12:0];
		end
	end

	always_comb begin
		z128  = {{3{z_q[7]}}, z_q, 7'b0};
		g_pre = prod_q - z128;
		b_pre = -prod_q - z128;
		x2    = {{2{x_q[7]}}, x_q, 1'b0};
		z2    = {{2{z_q[7]}}, z_q, 1'b0};
	end

	assign ph_inc = (level_q >= 13'd512) ? ({3'b0, level_q} - 16'd256) : 16'd256;

	always_comb begin
		t0 = $signed({2'b0, phase_q[15:8]}) - 10'sd64;
		t1 = (t0 >= 10'sd64) ? (10'sd128 - t0) : t0;
	end

	always_comb begin
		case (ctrl.mul_sel)
			sdtc_pkg::MUL_SQ: begin
				mul_a = $signed({2'b0, shake_q});
				mul_b = $signed({2'b0, shake_q});
			end
			sdtc_pkg::MUL_Y: begin
				mul_a = {y_q[7], y_q};
				mul_b = 9'sd222;
			end
			sdtc_pkg::MUL_T: begin
				mul_a = t1[8:0];
				mul_b = $signed({1'b0, level_q[12:5]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		offs     = prod_q[14:6];
		apply    = !flick_q || ({2'b0, level_q[12:7]} > sdtc_pkg::bitrev8(offs[7:0]));
		offs_add = apply ? {{3{offs[8]}}, offs} : 12'sd0;
		sum_r    = {r_q[10], r_q} + offs_add;
		sum_g    = {g_q[10], g_q} + offs_add;
		sum_b    = {b_q[10], b_q} + offs_add;
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign fail      = fail_q;
	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
			level_q     <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.ld_level) begin
				if (px_q != 0 || py_q != 0 || pz_q != 0) begin
					level_q <= level_n;
				end
				px_q <= x_q;
				py_q <= y_q;
				pz_q <= z_q;
			end
			if (ctrl.ld_phase) begin
				phase_q <= phase_q + ph_inc;
			end
			if (ctrl.emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q     <= accel_x;
			y_q     <= accel_y;
			z_q     <= accel_z;
			flick_q <= flicker;
			fail_q  <= read_failed;
		end
		if (ctrl.ld_shake) begin
			shake_q <= shake_n;
		end
		if (ctrl.ld_prod) begin
			prod_q <= 18'(mul_a * mul_b);
		end
		if (ctrl.ld_base) begin
			r_q <= z2 - x2;
			g_q <= g_pre[17:7] - x2;
			b_q <= b_pre[17:7] - x2;
		end
		if (ctrl.emit && out_free) begin
			if (ctrl.black) begin
				red_q   <= 8'd0;
				green_q <= 8'd0;
				blue_q  <= 8'd0;
			end else begin
				red_q   <= sdtc_pkg::clamp_byte(sum_r);
				green_q <= sdtc_pkg::clamp_byte(sum_g);
				blue_q  <= sdtc_pkg::clamp_byte(sum_b);
			end
		end
	end

endmodule

FILE: rtl/core/shake_driven_tilt_color.sv
// shake_driven_tilt_color: top level; one sample word in, one RGB word out.
// A failed read skips the multiply steps and gives a black word. No new sample
// word is taken until the microcode program, stepping through one shared
// multiplier and datapath, has emitted the last one's output; a stalled output holds it.
// Reset (arst_n low): clears previous sample, instability, phase, output valid and busy.
// Depends on sdtc_pkg, sdtc_seq and sdtc_dp.
module shake_driven_tilt_color (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [7:0] accel_x,
	input  logic signed [7:0] accel_y,
	input  logic signed [7:0] accel_z,
	input  logic              flicker,
	input  logic              read_failed,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue
);

	logic            busy;
	logic            start;
	logic            fail;
	logic            out_free;
	sdtc_pkg::ctrl_t ctrl;

	assign in_stall = busy;
	assign start    = in_valid && !busy;

	sdtc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.fail     (fail),
		.out_free (out_free),
		.busy     (busy),
		.ctrl     (ctrl)
	);

	sdtc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.flicker     (flicker),
		.read_failed (read_failed),
		.ctrl        (ctrl),
		.out_stall   (out_stall),
		.fail        (fail),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted word did not start the sequencer");

	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(busy))
		else $error("output word appeared without a word in progress");

	a_black_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit && ctrl.black && out_free |=> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("failed read did not give black");

	a_emit_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> busy && in_stall)
		else $error("emit step outside a word in progress");
`endif

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking bench for shake_driven_tilt_color; drives sample words and checks
// the RGB words against an in-bench model of shake, instability, phase and tilt color.
// Depends on shake_driven_tilt_color; runs through idle, stall and back-pressure phases.
`timescale 1ns / 100ps

module tb;

	localparam int WATCH_LIMIT = 4000;
	localparam int PRESS_CYC   = 300;

	typedef struct packed {
		logic signed [7:0] x;
		logic signed [7:0] y;
		logic signed [7:0] z;
		logic              flick;
		logic              fail;
	} sample_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic signed [7:0] accel_x;
	logic signed [7:0] accel_y;
	logic signed [7:0] accel_z;
	logic              flicker;
	logic              read_failed;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        red;
	logic [7:0]        green;
	logic [7:0]        blue;

	sample_t pend_q[$];
	color_t  color_q[$];

	// model state
	logic signed [7:0] last_x = '0;
	logic signed [7:0] last_y = '0;
	logic signed [7:0] last_z = '0;
	logic [12:0]       unrest = '0;
	logic [15:0]       phase  = '0;

	int  send_idle  = 0;
	int  stall_pct  = 0;
	logic hold_tog  = 1'b0;
	logic hold_ack;
	int  hold_left;
	int  quiet;
	int  errors     = 0;
	int  n_sent     = 0;
	int  n_checked  = 0;
	int  n_failed   = 0;
	int  peak_level = 0;
	int  gen_x      = 0;
	int  gen_y      = 0;
	int  gen_z      = 0;
	sample_t nxt;
	color_t  want;

	shake_driven_tilt_color i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.flicker    (flicker),
		.read_failed(read_failed),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int mag(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [7:0] sat_byte(input int v);
		if (v < 0) begin
			return 8'd0;
		end
		if (v > 255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	function automatic color_t predict_color(input sample_t s);
		int x, y, z, lvl, shake, r, g, b, t, offs;
		logic [7:0] rev;
		color_t c;
		x = s.x;
		y = s.y;
		z = s.z;
		if (s.fail) begin
			n_failed++;
			return '0;
		end
		if (last_x != 0 || last_y != 0 || last_z != 0) begin
			shake = mag(last_z - z) / 2 + mag(last_y - y) / 2 + mag(last_x - x) / 2;
			if (shake > 127) begin
				shake = 127;
			end
			lvl = int'(unrest) + shake * shake - 5;
			if (lvl < 0) begin
				lvl = 0;
			end
			if (lvl > 8191) begin
				lvl = 8191;
			end
			unrest = lvl[12:0];
		end
		last_x = s.x;
		last_y = s.y;
		last_z = s.z;
		r = ((z * 256) >>> 7) - 2 * x;
		g = ((222 * y - 128 * z) >>> 7) - 2 * x;
		b = ((-222 * y - 128 * z) >>> 7) - 2 * x;
		lvl = int'(unrest);
		if (lvl > peak_level) begin
			peak_level = lvl;
		end
		if (lvl >= 512) begin
			phase = phase + 16'(lvl - 256);
		end else begin
			phase = phase + 16'd256;
		end
		t = int'(phase[15:8]) - 64;
		if (t >= 64) begin
			t = 128 - t;
		end
		offs = (t * (lvl >>> 5)) >>> 6;
		for (int i = 0; i < 8; i++) begin
			rev[i] = offs[7-i];
		end
		if (!s.flick || (lvl >>> 7) > int'(rev)) begin
			r += offs;
			g += offs;
			b += offs;
		end
		c.red   = sat_byte(r);
		c.green = sat_byte(g);
		c.blue  = sat_byte(b);
		return c;
	endfunction

	// driver: hold a stalled word, advance on accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			accel_x     <= '0;
			accel_y     <= '0;
			accel_z     <= '0;
			flicker     <= 1'b0;
			read_failed <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				color_q.push_back(predict_color(
					sample_t'({accel_x, accel_y, accel_z, flicker, read_failed})));
				n_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					nxt = pend_q.pop_front();
					in_valid    <= 1'b1;
					accel_x     <= nxt.x;
					accel_y     <= nxt.y;
					accel_z     <= nxt.z;
					flicker     <= nxt.flick;
					read_failed <= nxt.fail;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted color word, drive stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_ack  <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (color_q.size() == 0) begin
					$error("unexpected color word %0d/%0d/%0d", red, green, blue);
					errors++;
				end else begin
					want = color_q.pop_front();
					n_checked++;
					if (red !== want.red) begin
						$error("red: expected %0d, got %0d", want.red, red);
						errors++;
					end
					if (green !== want.green) begin
						$error("green: expected %0d, got %0d", want.green, green);
						errors++;
					end
					if (blue !== want.blue) begin
						$error("blue: expected %0d, got %0d", want.blue, blue);
						errors++;
					end
				end
			end
			if (hold_tog != hold_ack) begin
				hold_ack  <= hold_tog;
				hold_left <= PRESS_CYC;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCH_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic push_sample(input int x, input int y, input int z,
		input bit flick, input bit fail);
		sample_t s;
		s.x     = x[7:0];
		s.y     = y[7:0];
		s.z     = z[7:0];
		s.flick = flick;
		s.fail  = fail;
		pend_q.push_back(s);
	endtask

	function automatic int wander(input int v, input int d);
		int n;
		n = v + int'($urandom_range(2 * d)) - d;
		if (n < -128) begin
			n = -128;
		end
		if (n > 127) begin
			n = 127;
		end
		return n;
	endfunction

	task automatic queue_random(input int n);
		int kind, len, fmode;
		bit fl;
		while (n > 0) begin
			kind  = $urandom_range(99);
			fmode = $urandom_range(2);
			if (kind < 5) begin
				len = 1 + $urandom_range(2);
			end else if (kind < 50) begin
				len = 20 + $urandom_range(130);
			end else begin
				len = 5 + $urandom_range(40);
			end
			repeat (len) begin
				if (kind < 5) begin
					gen_x = 0;
					gen_y = 0;
					gen_z = 0;
				end else if (kind < 20) begin
					gen_x = int'($urandom_range(255)) - 128;
					gen_y = int'($urandom_range(255)) - 128;
					gen_z = int'($urandom_range(255)) - 128;
				end else if (kind < 50) begin
					gen_x = wander(gen_x, 1);
					gen_y = wander(gen_y, 1);
					gen_z = wander(gen_z, 1);
				end else begin
					gen_x = wander(gen_x, 6);
					gen_y = wander(gen_y, 6);
					gen_z = wander(gen_z, 6);
				end
				fl = (fmode == 2) ? 1'($urandom_range(1)) : fmode[0];
				push_sample(gen_x, gen_y, gen_z, fl, $urandom_range(99) < 4);
				n--;
			end
		end
	endtask

	task automatic wait_drained();
		while (pend_q.size() != 0 || in_valid || color_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// first sample after reset, saturate, read failures, flicker, zero sample
		push_sample(0, 0, 0, 0, 0);
		push_sample(127, 127, 127, 0, 0);
		push_sample(-128, -128, -128, 0, 0);
		push_sample(127, -128, 0, 0, 1);
		push_sample(127, 127, 127, 0, 0);
		push_sample(-128, 127, -128, 1, 0);
		push_sample(127, -128, 127, 1, 0);
		push_sample(0, 0, 0, 0, 0);
		push_sample(5, -3, 7, 0, 0);
		push_sample(5, -3, 7, 1, 0);
		push_sample(5, -3, 7, 0, 0);
		push_sample(6, -2, 8, 1, 0);
		push_sample(1, 0, 0, 0, 0);
		push_sample(-1, -1, -1, 1, 0);
		push_sample(-128, 127, 0, 1, 1);
		push_sample(127, 0, -128, 0, 0);
		push_sample(-128, 0, 127, 1, 0);
		push_sample(0, 127, 0, 0, 0);
		push_sample(0, -128, 0, 1, 0);
		push_sample(-128, -128, 127, 0, 0);
		push_sample(127, 127, -128, 1, 0);
		push_sample(0, 0, 0, 1, 1);
		wait_drained();

		queue_random(480);
		wait_drained();

		send_idle = 64;
		queue_random(480);
		wait_drained();

		send_idle = 0;
		stall_pct = 64;
		queue_random(480);
		wait_drained();

		send_idle = 10;
		stall_pct = 10;
		queue_random(460);
		wait_drained();

		// long receiver hold while the sender keeps offering
		send_idle = 0;
		stall_pct = 0;
		hold_tog  = ~hold_tog;
		queue_random(60);
		wait_drained();

		repeat (20) @(negedge clk);
		$display("run: %0d samples sent, %0d colors checked, %0d failed reads",
			n_sent, n_checked, n_failed);
		$display("phases: free, sender idle, receiver stall, mixed, long hold; peak level %0d",
			peak_level);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
